// File: rtl/clp_pkg.sv
// ============================================================================
// clp_pkg
// Shared codes, character constants and keyword tables for the colon
// command line parser.
// ============================================================================
package clp_pkg;

  // Default sizes
  localparam int LINE_BUF_BYTES_DEF  = 64;
  localparam int USER_ID_BYTES_DEF   = 8;
  localparam int DEVICE_ID_BYTES_DEF = 16;
  localparam int TIMESTAMP_BYTES_DEF = 24;

  // Result kinds
  localparam logic [1:0] KIND_CMD    = 2'd0;
  localparam logic [1:0] KIND_USER   = 2'd1;
  localparam logic [1:0] KIND_DEVICE = 2'd2;
  localparam logic [1:0] KIND_TIME   = 2'd3;

  // Command codes
  localparam logic [2:0] CMD_UNKNOWN  = 3'd0;
  localparam logic [2:0] CMD_SCAN     = 3'd1;
  localparam logic [2:0] CMD_STOP     = 3'd2;
  localparam logic [2:0] CMD_CAPTURE  = 3'd3;
  localparam logic [2:0] CMD_SHUTDOWN = 3'd4;
  localparam logic [2:0] CMD_SAVE     = 3'd5;

  // Characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_COLON = 8'h3A;

  // Fixed keywords
  typedef enum logic [2:0] {
    WORD_PREFIX,
    WORD_SCAN,
    WORD_STOP,
    WORD_CAPTURE,
    WORD_SHUTDOWN,
    WORD_SAVE
  } word_t;

  // Handoff from the capture side to the decoder at the end of a line
  typedef struct packed {
    logic start;
    logic prefix_ok;
  } line_done_t;

  // Keyword length in characters
  function automatic logic [3:0] word_len(input word_t w);
    logic [3:0] len;
    unique case (w)
      WORD_PREFIX:   len = 4'd4;
      WORD_SCAN:     len = 4'd4;
      WORD_STOP:     len = 4'd4;
      WORD_CAPTURE:  len = 4'd7;
      WORD_SHUTDOWN: len = 4'd8;
      WORD_SAVE:     len = 4'd5;
      default:       len = 4'd0;
    endcase
    return len;
  endfunction

  // Keyword character at a position, left-aligned text, first char on top
  function automatic logic [7:0] word_char(input word_t w, input logic [2:0] idx);
    logic [63:0] text;
    unique case (w)
      WORD_PREFIX:   text = {"CMD:", 32'h0};
      WORD_SCAN:     text = {"SCAN", 32'h0};
      WORD_STOP:     text = {"STOP", 32'h0};
      WORD_CAPTURE:  text = {"CAPTURE", 8'h0};
      WORD_SHUTDOWN: text = "SHUTDOWN";
      WORD_SAVE:     text = {"SAVE:", 24'h0};
      default:       text = 64'h0;
    endcase
    return text[63 - 8 * idx -: 8];
  endfunction

endpackage

// File: rtl/clp_line_mem.sv
// ============================================================================
// clp_line_mem
// Line body store: one write port, one read port, registered read data.
// ============================================================================
module clp_line_mem
  import clp_pkg::*;
#(
  parameter int DEPTH  = LINE_BUF_BYTES_DEF - 1,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [DEPTH];

  // Write one byte
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read one byte, held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/clp_capture.sv
// ============================================================================
// clp_capture
// Input side: matches the line prefix, stores body bytes and hands the
// finished line to the decoder.
// ============================================================================
module clp_capture
  import clp_pkg::*;
#(
  parameter int LINE_BUF_BYTES = LINE_BUF_BYTES_DEF,
  parameter int DEPTH          = LINE_BUF_BYTES - 1,
  parameter int ADDR_W         = $clog2(DEPTH),
  parameter int CNT_W          = $clog2(LINE_BUF_BYTES)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  input  logic              ready,
  input  logic [7:0]        s_axis_tdata,
  input  logic              s_axis_tlast,
  output line_done_t        done,
  output logic [CNT_W-1:0]  line_length,
  output logic              wr_en,
  output logic [ADDR_W-1:0] wr_addr,
  output logic [7:0]        wr_data
);

  localparam logic [2:0] PREFIX_LEN = 3'(word_len(WORD_PREFIX));

  logic [2:0] prefix_pos;
  logic       prefix_failed;
  logic       line_ended;
  logic       accept;
  logic       body_full;
  logic       in_body;
  logic       prefix_hit;

  assign accept     = s_axis_tvalid && ready;
  assign body_full  = (line_length == CNT_W'(DEPTH));
  assign in_body    = !prefix_failed && !line_ended && (prefix_pos == PREFIX_LEN);
  assign prefix_hit = (s_axis_tdata == word_char(WORD_PREFIX, {1'b0, prefix_pos[1:0]}));

  // Store body bytes until the buffer is full
  assign wr_en   = accept && !s_axis_tlast && in_body && (s_axis_tdata != CH_NUL) && !body_full;
  assign wr_addr = line_length[ADDR_W-1:0];
  assign wr_data = s_axis_tdata;

  // Hand off at the end marker
  assign done.start     = accept && s_axis_tlast;
  assign done.prefix_ok = !prefix_failed && (prefix_pos == PREFIX_LEN);

  // Track prefix, early end and body length
  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_pos    <= '0;
      prefix_failed <= 1'b0;
      line_ended    <= 1'b0;
      line_length   <= '0;
    end else if (accept) begin
      if (s_axis_tlast) begin
        prefix_pos    <= '0;
        prefix_failed <= 1'b0;
        line_ended    <= 1'b0;
        line_length   <= '0;
      end else if (!prefix_failed && !line_ended) begin
        if (prefix_pos != PREFIX_LEN) begin
          if (prefix_hit) begin
            prefix_pos <= prefix_pos + 3'd1;
          end else begin
            prefix_failed <= 1'b1;
          end
        end else if (s_axis_tdata == CH_NUL) begin
          line_ended <= 1'b1;
        end else if (!body_full) begin
          line_length <= line_length + 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/clp_decode.sv
// ============================================================================
// clp_decode
// End-of-line sequencer: trims CR/LF, scans the stored body for keywords
// and colons, then emits the command and the SAVE field bytes.
// ============================================================================
module clp_decode
  import clp_pkg::*;
#(
  parameter int LINE_BUF_BYTES  = LINE_BUF_BYTES_DEF,
  parameter int USER_ID_BYTES   = USER_ID_BYTES_DEF,
  parameter int DEVICE_ID_BYTES = DEVICE_ID_BYTES_DEF,
  parameter int TIMESTAMP_BYTES = TIMESTAMP_BYTES_DEF,
  parameter int DEPTH           = LINE_BUF_BYTES - 1,
  parameter int ADDR_W          = $clog2(DEPTH),
  parameter int CNT_W           = $clog2(LINE_BUF_BYTES)
) (
  input  logic              clk,
  input  logic              rst,
  input  line_done_t        done,
  input  logic [CNT_W-1:0]  line_length,
  output logic              idle,
  output logic              rd_en,
  output logic [ADDR_W-1:0] rd_addr,
  input  logic [7:0]        rd_data,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [15:0]       m_axis_tdata,
  output logic [1:0]        m_axis_tuser,
  output logic              m_axis_tlast
);

  localparam int CMP_W = CNT_W + 6;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TRIM_RD,
    S_TRIM_EV,
    S_SCAN_RD,
    S_SCAN_EV,
    S_CHECK,
    S_CMD,
    S_EM_RD,
    S_EM_WR
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] n;
  logic [CNT_W-1:0] i;
  logic [CNT_W-1:0] s1;
  logic [CNT_W-1:0] s2;
  logic             found1;
  logic             found2;
  logic             ok_scan;
  logic             ok_stop;
  logic             ok_capture;
  logic             ok_shutdown;
  logic             ok_save;
  logic [2:0]       cmd_code;
  logic             save_go;
  logic [2:0]       out_cmd;
  logic [7:0]       out_byte;

  logic             out_free;
  logic             out_load;
  logic [CNT_W-1:0] n_m1;
  logic             is_crlf;
  logic             is_colon;
  logic             em_skip;
  logic             hit_scan;
  logic             hit_stop;
  logic             hit_capture;
  logic             hit_shutdown;
  logic             hit_save;
  logic [CMP_W-1:0] nw;
  logic [CMP_W-1:0] s1w;
  logic [CMP_W-1:0] s2w;
  logic             user_ok;
  logic             dev_ok;
  logic             ts_ok;
  logic             save_valid;
  logic [2:0]       cmd_sel;
  logic [1:0]       em_kind;

  assign idle     = (state == S_IDLE);
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign out_load = ((state == S_CMD) || (state == S_EM_WR)) && out_free;
  assign n_m1     = n - 1'b1;
  assign is_crlf  = (rd_data == CH_LF) || (rd_data == CH_CR);
  assign is_colon = (rd_data == CH_COLON);
  assign em_skip  = (i == s1) || (i == s2);

  // Memory read port
  assign rd_en   = (state == S_TRIM_RD) || (state == S_SCAN_RD) ||
                   ((state == S_EM_RD) && !em_skip);
  assign rd_addr = (state == S_TRIM_RD) ? n_m1[ADDR_W-1:0] : i[ADDR_W-1:0];

  // Per-byte keyword compares; positions past a word's end always pass
  assign hit_scan     = (i >= CNT_W'(word_len(WORD_SCAN))) ||
                        (rd_data == word_char(WORD_SCAN, i[2:0]));
  assign hit_stop     = (i >= CNT_W'(word_len(WORD_STOP))) ||
                        (rd_data == word_char(WORD_STOP, i[2:0]));
  assign hit_capture  = (i >= CNT_W'(word_len(WORD_CAPTURE))) ||
                        (rd_data == word_char(WORD_CAPTURE, i[2:0]));
  assign hit_shutdown = (i >= CNT_W'(word_len(WORD_SHUTDOWN))) ||
                        (rd_data == word_char(WORD_SHUTDOWN, i[2:0]));
  assign hit_save     = (i >= CNT_W'(word_len(WORD_SAVE))) ||
                        (rd_data == word_char(WORD_SAVE, i[2:0]));

  // SAVE field length checks
  assign nw  = CMP_W'(n);
  assign s1w = CMP_W'(s1);
  assign s2w = CMP_W'(s2);
  assign user_ok = found1 && (s1w > CMP_W'(word_len(WORD_SAVE))) &&
                   (s1w < CMP_W'(word_len(WORD_SAVE)) + CMP_W'(USER_ID_BYTES));
  assign dev_ok  = found2 && (s2w > s1w + CMP_W'(1)) &&
                   (s2w < s1w + CMP_W'(DEVICE_ID_BYTES + 1));
  assign ts_ok   = (nw > s2w + CMP_W'(1)) && (nw < s2w + CMP_W'(TIMESTAMP_BYTES + 1));
  assign save_valid = ok_save && (nw >= CMP_W'(word_len(WORD_SAVE))) &&
                      user_ok && dev_ok && ts_ok;

  // Pick the command code
  always_comb begin
    if (ok_scan && (n == CNT_W'(word_len(WORD_SCAN)))) begin
      cmd_sel = CMD_SCAN;
    end else if (ok_stop && (n == CNT_W'(word_len(WORD_STOP)))) begin
      cmd_sel = CMD_STOP;
    end else if (ok_capture && (n == CNT_W'(word_len(WORD_CAPTURE)))) begin
      cmd_sel = CMD_CAPTURE;
    end else if (ok_shutdown && (n == CNT_W'(word_len(WORD_SHUTDOWN)))) begin
      cmd_sel = CMD_SHUTDOWN;
    end else if (save_valid) begin
      cmd_sel = CMD_SAVE;
    end else begin
      cmd_sel = CMD_UNKNOWN;
    end
  end

  // Field tag of the byte being emitted
  always_comb begin
    if (i < s1) begin
      em_kind = KIND_USER;
    end else if (i < s2) begin
      em_kind = KIND_DEVICE;
    end else begin
      em_kind = KIND_TIME;
    end
  end

  assign m_axis_tdata = {5'b0, out_byte, out_cmd};

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      // Load a new result, or drop the request once taken
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (done.start) begin
            n           <= line_length;
            found1      <= 1'b0;
            found2      <= 1'b0;
            s1          <= '0;
            s2          <= '0;
            ok_scan     <= 1'b1;
            ok_stop     <= 1'b1;
            ok_capture  <= 1'b1;
            ok_shutdown <= 1'b1;
            ok_save     <= 1'b1;
            if (!done.prefix_ok) begin
              cmd_code <= CMD_UNKNOWN;
              save_go  <= 1'b0;
              state    <= S_CMD;
            end else if (line_length == '0) begin
              state <= S_CHECK;
            end else begin
              state <= S_TRIM_RD;
            end
          end
        end
        S_TRIM_RD: begin
          state <= S_TRIM_EV;
        end
        S_TRIM_EV: begin
          // Drop trailing CR/LF one at a time
          if (is_crlf) begin
            n     <= n_m1;
            state <= (n_m1 == '0) ? S_CHECK : S_TRIM_RD;
          end else begin
            i     <= '0;
            state <= S_SCAN_RD;
          end
        end
        S_SCAN_RD: begin
          state <= S_SCAN_EV;
        end
        S_SCAN_EV: begin
          ok_scan     <= ok_scan && hit_scan;
          ok_stop     <= ok_stop && hit_stop;
          ok_capture  <= ok_capture && hit_capture;
          ok_shutdown <= ok_shutdown && hit_shutdown;
          ok_save     <= ok_save && hit_save;
          // Mark the first two colons after the SAVE: keyword
          if ((i >= CNT_W'(word_len(WORD_SAVE))) && is_colon) begin
            if (!found1) begin
              found1 <= 1'b1;
              s1     <= i;
            end else if (!found2) begin
              found2 <= 1'b1;
              s2     <= i;
            end
          end
          if (i == n_m1) begin
            state <= S_CHECK;
          end else begin
            i     <= i + 1'b1;
            state <= S_SCAN_RD;
          end
        end
        S_CHECK: begin
          cmd_code <= cmd_sel;
          save_go  <= (cmd_sel == CMD_SAVE);
          state    <= S_CMD;
        end
        S_CMD: begin
          if (out_free) begin
            m_axis_tuser  <= KIND_CMD;
            out_cmd       <= cmd_code;
            out_byte      <= 8'h00;
            m_axis_tlast  <= !save_go;
            if (save_go) begin
              i     <= CNT_W'(word_len(WORD_SAVE));
              state <= S_EM_RD;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_EM_RD: begin
          // Skip the separating colons
          if (em_skip) begin
            i <= i + 1'b1;
          end else begin
            state <= S_EM_WR;
          end
        end
        S_EM_WR: begin
          if (out_free) begin
            m_axis_tuser  <= em_kind;
            out_cmd       <= CMD_SAVE;
            out_byte      <= rd_data;
            m_axis_tlast  <= (i == n_m1);
            if (i == n_m1) begin
              state <= S_IDLE;
            end else begin
              i     <= i + 1'b1;
              state <= S_EM_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/colon_command_line_parser.sv
// ============================================================================
// colon_command_line_parser
// Parses "CMD:" lines into command codes and streams SAVE field bytes.
// ============================================================================
//
//  Channel   Dir  Signals                         Contents
//  s_axis    in   tvalid tready tdata[7:0] tlast  tdata: ch; tlast: end of line
//  m_axis    out  tvalid tready tdata[15:0]       tdata: command, text_byte;
//                 tuser[1:0] tlast                tuser: kind; tlast: last
//
//  Line bytes are taken one per cycle. The end marker starts the decoder;
//  input is held off until the last result of the line sits in the output
//  register. The decoder reads the kept body back through the single read
//  port of the line store, whose read data is registered: it trims trailing
//  CR/LF from the end, scans each byte for keywords and colons, then reads
//  each SAVE field byte again to emit it; the separating colons are skipped
//  unread. A bad prefix goes straight to the command result.
//  Reset clears the sequencer and capture state; the line store is not cleared.
//  A stall on m_axis holds the sequencer at the next result.
//
module colon_command_line_parser
  import clp_pkg::*;
#(
  parameter int LINE_BUF_BYTES  = LINE_BUF_BYTES_DEF,
  parameter int USER_ID_BYTES   = USER_ID_BYTES_DEF,
  parameter int DEVICE_ID_BYTES = DEVICE_ID_BYTES_DEF,
  parameter int TIMESTAMP_BYTES = TIMESTAMP_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] ch
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [2:0] command, [10:3] text_byte, [15:11] zero
  output logic [1:0]  m_axis_tuser,   // [1:0] kind
  output logic        m_axis_tlast
);

  localparam int DEPTH  = LINE_BUF_BYTES - 1;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(LINE_BUF_BYTES);

  line_done_t        done;
  logic [CNT_W-1:0]  line_length;
  logic              idle;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;

  // Take requests only while the decoder is free
  assign s_axis_tready = idle;

  clp_capture #(
    .LINE_BUF_BYTES (LINE_BUF_BYTES),
    .DEPTH          (DEPTH),
    .ADDR_W         (ADDR_W),
    .CNT_W          (CNT_W)
  ) u_capture (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .ready         (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .done          (done),
    .line_length   (line_length),
    .wr_en         (wr_en),
    .wr_addr       (wr_addr),
    .wr_data       (wr_data)
  );

  clp_line_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_line_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  clp_decode #(
    .LINE_BUF_BYTES  (LINE_BUF_BYTES),
    .USER_ID_BYTES   (USER_ID_BYTES),
    .DEVICE_ID_BYTES (DEVICE_ID_BYTES),
    .TIMESTAMP_BYTES (TIMESTAMP_BYTES),
    .DEPTH           (DEPTH),
    .ADDR_W          (ADDR_W),
    .CNT_W           (CNT_W)
  ) u_decode (
    .clk           (clk),
    .rst           (rst),
    .done          (done),
    .line_length   (line_length),
    .idle          (idle),
    .rd_en         (rd_en),
    .rd_addr       (rd_addr),
    .rd_data       (rd_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Input is held off while a line is being decoded
  a_hold_after_eol: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
    else $error("input accepted right after end of line");

  // Field bytes always belong to a SAVE command
  a_field_is_save: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser != KIND_CMD)) |-> (m_axis_tdata[2:0] == CMD_SAVE))
    else $error("field byte without SAVE command");

  // A SAVE command is never the final result of its line
  a_save_not_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser == KIND_CMD) && (m_axis_tdata[2:0] == CMD_SAVE))
      |-> !m_axis_tlast)
    else $error("SAVE command marked last");

endmodule

// File: verif/clp_line_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// clp_line_checker
// Watches both stream channels of the command line parser, decodes each
// accepted line on its own and compares every result field by field.
// ============================================================================
module clp_line_checker
  import clp_pkg::*;
#(
  parameter int LINE_BUF_BYTES  = LINE_BUF_BYTES_DEF,
  parameter int USER_ID_BYTES   = USER_ID_BYTES_DEF,
  parameter int DEVICE_ID_BYTES = DEVICE_ID_BYTES_DEF,
  parameter int TIMESTAMP_BYTES = TIMESTAMP_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] ch
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,   // [2:0] command, [10:3] text_byte, [15:11] zero
  input  logic [1:0]  m_axis_tuser,   // [1:0] kind
  input  logic        m_axis_tlast,
  output int          fail_count,
  output int          results_due
);

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] command;
    logic [7:0] text_byte;
    logic       last;
  } result_t;

  localparam logic [31:0] PREFIX_TEXT = "CMD:";

  result_t    due_results[$];
  logic [7:0] body [LINE_BUF_BYTES-1];
  int         body_len;
  int         prefix_pos;
  bit         prefix_bad;
  bit         line_cut;
  int         mismatches;

  // True when the kept body holds at least the word and starts with it
  function automatic bit body_begins(input string w, input int n);
    if (n < w.len()) return 1'b0;
    for (int i = 0; i < w.len(); i++)
      if (body[i] != w[i]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic push_result(input logic [1:0] k, input logic [2:0] c,
                             input logic [7:0] b, input logic l);
    result_t r;
    r.kind      = k;
    r.command   = c;
    r.text_byte = b;
    r.last      = l;
    due_results.push_back(r);
  endtask

  // Decode the finished line into its command and, for SAVE, the field bytes
  task automatic decode_line();
    int         n;
    int         s1;
    int         s2;
    logic [2:0] code;
    code = CMD_UNKNOWN;
    n    = body_len;
    s1   = 0;
    s2   = 0;
    if (!prefix_bad && prefix_pos == 4) begin
      // trim trailing CR and LF
      while (n > 0 && (body[n-1] == CH_LF || body[n-1] == CH_CR)) n--;
      if (n == 4 && body_begins("SCAN", n)) code = CMD_SCAN;
      else if (n == 4 && body_begins("STOP", n)) code = CMD_STOP;
      else if (n == 7 && body_begins("CAPTURE", n)) code = CMD_CAPTURE;
      else if (n == 8 && body_begins("SHUTDOWN", n)) code = CMD_SHUTDOWN;
      else if (body_begins("SAVE:", n)) begin
        s1 = 5;
        while (s1 < n && body[s1] != CH_COLON) s1++;
        s2 = s1 + 1;
        while (s2 < n && body[s2] != CH_COLON) s2++;
        if (s1 < n && s2 < n &&
            s1 - 5 >= 1 && s1 - 5 < USER_ID_BYTES &&
            s2 - s1 - 1 >= 1 && s2 - s1 - 1 < DEVICE_ID_BYTES &&
            n - s2 - 1 >= 1 && n - s2 - 1 < TIMESTAMP_BYTES)
          code = CMD_SAVE;
      end
    end
    if (code != CMD_SAVE) begin
      push_result(KIND_CMD, code, 8'h00, 1'b1);
    end else begin
      push_result(KIND_CMD, CMD_SAVE, 8'h00, 1'b0);
      for (int i = 5; i < s1; i++) push_result(KIND_USER, CMD_SAVE, body[i], 1'b0);
      for (int i = s1 + 1; i < s2; i++) push_result(KIND_DEVICE, CMD_SAVE, body[i], 1'b0);
      for (int i = s2 + 1; i < n; i++)
        push_result(KIND_TIME, CMD_SAVE, body[i], i == n - 1);
    end
  endtask

  // Track requests in, compare results out
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst) begin
      due_results.delete();
      body_len   = 0;
      prefix_pos = 0;
      prefix_bad = 1'b0;
      line_cut   = 1'b0;
      mismatches = 0;
    end else begin
      // compare an accepted result with the oldest expectation
      if (m_axis_tvalid && m_axis_tready) begin
        got.kind      = m_axis_tuser;
        got.command   = m_axis_tdata[2:0];
        got.text_byte = m_axis_tdata[10:3];
        got.last      = m_axis_tlast;
        if (due_results.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected result kind %0d cmd %0d byte %02h last %0d",
                     $realtime, got.kind, got.command, got.text_byte, got.last);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          if (got != want) begin
            if (mismatches < 10)
              $display({"%0t: result mismatch: expected kind %0d cmd %0d byte %02h ",
                        "last %0d, got kind %0d cmd %0d byte %02h last %0d"},
                       $realtime, want.kind, want.command, want.text_byte, want.last,
                       got.kind, got.command, got.text_byte, got.last);
            mismatches++;
          end
        end
      end
      // advance the line state on an accepted request
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tlast) begin
          decode_line();
          body_len   = 0;
          prefix_pos = 0;
          prefix_bad = 1'b0;
          line_cut   = 1'b0;
        end else if (!prefix_bad && !line_cut) begin
          if (prefix_pos < 4) begin
            if (s_axis_tdata != PREFIX_TEXT[31 - 8 * prefix_pos -: 8]) prefix_bad = 1'b1;
            else prefix_pos++;
          end else if (s_axis_tdata == CH_NUL) begin
            line_cut = 1'b1;
          end else if (body_len < LINE_BUF_BYTES - 1) begin
            body[body_len] = s_axis_tdata;
            body_len++;
          end
        end
      end
    end
    fail_count  <= mismatches;
    results_due <= due_results.size();
  end

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb
// Stimulus for the colon command line parser: directed lines for every
// command and the main corners of the SAVE fields, then random lines, with
// random gaps on both channels. The line checker beside the block compares.
// ============================================================================
module tb;
  import clp_pkg::*;

  localparam int LIMIT      = 200000;
  localparam int ITEM_GOAL  = 250;
  localparam int TAIL_WAIT  = 300;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;

  int         fail_count;
  int         results_due;
  int         cycles;
  int         items_sent;
  bit         steady;
  logic [7:0] line_q[$];
  string      words[4] = '{"SCAN", "STOP", "CAPTURE", "SHUTDOWN"};

  colon_command_line_parser uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  clp_line_checker line_chk (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count    (fail_count),
    .results_due   (results_due)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Stall the result channel at random
  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= steady || ($urandom_range(0, 99) >= 12);
  end

  // Give up at the cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Send one request, with random gaps ahead of it
  task automatic send_byte(input logic [7:0] c, input logic eol);
    while (!steady && $urandom_range(0, 99) < 12) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= eol;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    items_sent++;
  endtask

  // Send the built line, then the end marker with a random ignored byte
  task automatic send_line();
    foreach (line_q[i]) send_byte(line_q[i], 1'b0);
    send_byte(8'($urandom_range(0, 255)), 1'b1);
    line_q.delete();
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endtask

  // Append n random non-zero bytes; colons only where allowed
  task automatic add_field(input int n, input bit with_colon);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom_range(1, 255));
      if (!with_colon && b == CH_COLON) b = b + 8'd1;
      line_q.push_back(b);
    end
  endtask

  task automatic add_line_end(input int n);
    for (int i = 0; i < n; i++) line_q.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
  endtask

  // Drop the request and hold the sender until every due result has come out
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
  endtask

  // Mostly short valid lengths, sometimes any valid length, sometimes zero or too long
  function automatic int pick_len(input int limit);
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return 0;
    if (r < 10) return limit + $urandom_range(0, 2);
    if (r < 25) return $urandom_range(1, limit - 1);
    return $urandom_range(1, 3);
  endfunction

  task automatic add_save(input int ulen, input int dlen, input int tlen);
    add_text("SAVE:");
    add_field(ulen, 1'b0);
    line_q.push_back(CH_COLON);
    add_field(dlen, 1'b0);
    line_q.push_back(CH_COLON);
    add_field(tlen, 1'b1);
  endtask

  initial begin
    int sel;
    int lines;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'h00;
    s_axis_tlast  <= 1'b0;
    rst           <= 1'b1;
    items_sent    = 0;
    steady        = 1'b0;
    lines         = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: every command, with no gaps on either side
    steady = 1'b1;
    add_text("CMD:SCAN");                       send_line();
    add_text("CMD:STOP"); add_line_end(2);      send_line();
    add_text("CMD:CAPTURE");                    send_line();
    add_text("CMD:SHUTDOWN"); add_line_end(1);  send_line();
    // SAVE at its smallest and largest fields
    add_text("CMD:"); add_save(1, 1, 1);        send_line();
    add_text("CMD:"); add_save(USER_ID_BYTES_DEF - 1, DEVICE_ID_BYTES_DEF - 1,
                               TIMESTAMP_BYTES_DEF - 1);
    send_line();
    steady = 1'b0;
    // SAVE with an empty timestamp
    add_text("CMD:"); add_save(1, 1, 0); add_line_end(1);        send_line();
    // timestamp with colons and a high-bit byte
    add_text("CMD:SAVE:u:d:1:2");
    line_q.push_back(8'hFF);
    send_line();
    // broken prefix
    add_text("CMX:SCAN");                       send_line();
    // zero byte ends the line early
    add_text("CMD:SC"); line_q.push_back(CH_NUL); add_text("AN");   send_line();
    // overlong body: dropped bytes before trimming
    add_text("CMD:SCAN"); add_line_end(60);     send_line();

    wait_drained();

    // Random lines, mostly well formed
    while (items_sent < ITEM_GOAL) begin
      steady = (lines >= 4 && lines < 8);
      sel = $urandom_range(0, 99);
      if (sel < 15) begin
        add_text("CMD:");
        add_text(words[$urandom_range(0, 3)]);
        if ($urandom_range(0, 9) == 0)
          line_q[$urandom_range(4, line_q.size() - 1)] = 8'($urandom_range(1, 255));
        add_line_end($urandom_range(0, 2));
      end else if (sel < 65) begin
        add_text("CMD:");
        add_save(pick_len(USER_ID_BYTES_DEF), pick_len(DEVICE_ID_BYTES_DEF),
                 pick_len(TIMESTAMP_BYTES_DEF));
        if ($urandom_range(0, 9) < 3) add_line_end($urandom_range(1, 2));
      end else if (sel < 75) begin
        if ($urandom_range(0, 1)) add_text("CMD:");
        for (int i = $urandom_range(0, 12); i > 0; i--)
          line_q.push_back(8'($urandom_range(0, 255)));
      end else if (sel < 85) begin
        add_text("CMD:STOP");
        line_q[$urandom_range(0, 3)] = 8'($urandom_range(0, 255));
      end else if (sel < 93) begin
        add_text("CMD:");
        add_save($urandom_range(1, 3), $urandom_range(1, 3), $urandom_range(1, 3));
        line_q.insert($urandom_range(0, line_q.size()), CH_NUL);
      end else begin
        add_text("CMD:STOP");
        if ($urandom_range(0, 1)) add_line_end($urandom_range(56, 70));
        else add_field($urandom_range(56, 70), 1'b1);
      end
      send_line();
      lines++;
      if (lines % 5 == 0) wait_drained();
    end
    steady = 1'b0;

    // Drain, then allow the decoder time for anything stray
    wait_drained();
    repeat (TAIL_WAIT) @(posedge clk);
    if (fail_count == 0 && results_due == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
